[hdl/bresenham_line_rasterizer_defines.svh]
// Assertion macros for the line rasterizer checker.
`ifndef BRESENHAM_LINE_RASTERIZER_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_DEFINES_SVH

// same-cycle implication, off while in reset
`define BLR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, off while in reset
`define BLR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// checked through reset
`define BLR_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[hdl/blr_pkg.sv]
`default_nettype none

package blr_pkg;

  localparam int MAX_DIM    = 2048;
  localparam int COORD_BITS = 16;
  localparam int DIM_BITS   = 12;
  localparam int ADDR_BITS  = 22;
  localparam int COLOR_BITS = 24;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLOR  = 2'd2;

  typedef enum logic {
    REQ_START   = 1'b0,
    REQ_ADVANCE = 1'b1
  } req_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    req_t   req_type;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } blr_in_t;

  typedef struct packed {
    coord_t                  pixel_x;
    coord_t                  pixel_y;
    logic                    write_enable;
    logic [ADDR_BITS-1:0]    pixel_address;
    logic [COLOR_BITS-1:0]   pixel_color;
    logic                    line_done;
    logic                    was_idle;
  } blr_out_t;

endpackage

`default_nettype wire

[hdl/bresenham_line_rasterizer.sv]
// Bresenham line rasterizer, all octants.
// Input channel (in_valid/in_stall/in_data): a REQ_START word loads both
// endpoints and yields the first pixel; each REQ_ADVANCE word yields the next
// pixel of the line. An advance with no line in progress yields a word with
// only was_idle set. Exactly one result word per input word, in order.
// Result channel (out_valid/out_stall/out_data): x, y, clip flag, linear
// address y*width+x, color and a flag on the end point.
// Config port (cfg_we/cfg_index/cfg_wdata): width, height, color; write only
// while no words are in flight.
// Throughput: one word per cycle while in_stall is low. The Bresenham step
// is done in the accept cycle and written to the pending register; the
// address multiply sits between the pending and output registers.
// Reset: no line active, pipeline empty, width 640, height 480, color 0.
// Stall: the pending and output registers hold two words; in_stall is high
// only while both are full and out_stall is high. Nothing is dropped.
`default_nettype none

module bresenham_line_rasterizer (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire blr_pkg::blr_in_t                 in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output blr_pkg::blr_out_t                     out_data,
  input  wire logic                             cfg_we,
  input  wire logic [blr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [blr_pkg::COLOR_BITS-1:0]   cfg_wdata
);
  import blr_pkg::*;

  localparam int DX_BITS  = COORD_BITS + 1;
  localparam int NDY_BITS = COORD_BITS + 2;
  localparam int ERR_BITS = COORD_BITS + 3;
  localparam int E2_BITS  = COORD_BITS + 4;
  localparam int IDX_BITS = DIM_BITS - 1;

  // config
  logic [DIM_BITS-1:0]   width_r, width_nxt;
  logic [DIM_BITS-1:0]   height_r, height_nxt;
  logic [COLOR_BITS-1:0] color_r, color_nxt;

  // line state
  coord_t                      cur_x_r, cur_x_nxt;
  coord_t                      cur_y_r, cur_y_nxt;
  coord_t                      end_x_r, end_x_nxt;
  coord_t                      end_y_r, end_y_nxt;
  logic [DX_BITS-1:0]          dx_r, dx_nxt;
  logic signed [NDY_BITS-1:0]  ndy_r, ndy_nxt;
  logic                        sx_neg_r, sx_neg_nxt;
  logic                        sy_neg_r, sy_neg_nxt;
  logic signed [ERR_BITS-1:0]  err_r, err_nxt;
  logic                        active_r, active_nxt;

  // pending stage
  logic   p_valid_r, p_valid_nxt;
  coord_t p_x_r, p_x_nxt;
  coord_t p_y_r, p_y_nxt;
  logic   p_done_r, p_done_nxt;
  logic   p_idle_r, p_idle_nxt;

  // output stage
  logic     out_valid_r, out_valid_nxt;
  blr_out_t out_data_r, out_data_nxt;

  logic accept, p_move;

  // start setup
  logic signed [DX_BITS-1:0]  sdx, sdy;
  logic [DX_BITS-1:0]         abs_dx, abs_dy;
  logic signed [NDY_BITS-1:0] init_ndy;
  logic signed [ERR_BITS-1:0] init_err;

  // advance step
  logic signed [E2_BITS-1:0]  e2;
  logic                       x_step, y_step;
  logic signed [ERR_BITS-1:0] err_adv;
  coord_t                     x_adv, y_adv;

  // output compute
  logic [DIM_BITS-1:0]  w_c, h_c;
  logic                 on_bitmap;
  logic [ADDR_BITS-1:0] addr;

  assign p_move   = p_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = p_valid_r && out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    color_nxt  = color_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  width_nxt  = cfg_wdata[DIM_BITS-1:0];
        CFG_HEIGHT: height_nxt = cfg_wdata[DIM_BITS-1:0];
        CFG_COLOR:  color_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    sdx      = {in_data.x_end[COORD_BITS-1], in_data.x_end}
             - {in_data.x_start[COORD_BITS-1], in_data.x_start};
    sdy      = {in_data.y_end[COORD_BITS-1], in_data.y_end}
             - {in_data.y_start[COORD_BITS-1], in_data.y_start};
    abs_dx   = sdx[DX_BITS-1] ? DX_BITS'(-sdx) : DX_BITS'(sdx);
    abs_dy   = sdy[DX_BITS-1] ? DX_BITS'(-sdy) : DX_BITS'(sdy);
    init_ndy = -$signed({1'b0, abs_dy});
    init_err = $signed({2'b00, abs_dx}) + ERR_BITS'(init_ndy);

    e2      = {err_r, 1'b0};
    x_step  = e2 >= E2_BITS'(ndy_r);
    y_step  = e2 <= $signed({3'b000, dx_r});
    err_adv = err_r
            + (x_step ? ERR_BITS'(ndy_r) : ERR_BITS'(0))
            + (y_step ? $signed({2'b00, dx_r}) : ERR_BITS'(0));
    x_adv   = cur_x_r + (x_step ? (sx_neg_r ? coord_t'(-1) : coord_t'(1)) : coord_t'(0));
    y_adv   = cur_y_r + (y_step ? (sy_neg_r ? coord_t'(-1) : coord_t'(1)) : coord_t'(0));
  end

  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    end_x_nxt  = end_x_r;
    end_y_nxt  = end_y_r;
    dx_nxt     = dx_r;
    ndy_nxt    = ndy_r;
    sx_neg_nxt = sx_neg_r;
    sy_neg_nxt = sy_neg_r;
    err_nxt    = err_r;
    active_nxt = active_r;
    p_x_nxt    = p_x_r;
    p_y_nxt    = p_y_r;
    p_done_nxt = p_done_r;
    p_idle_nxt = p_idle_r;
    p_valid_nxt = p_move ? 1'b0 : p_valid_r;
    if (accept) begin
      p_valid_nxt = 1'b1;
      p_idle_nxt  = 1'b0;
      if (in_data.req_type == REQ_START) begin
        cur_x_nxt  = in_data.x_start;
        cur_y_nxt  = in_data.y_start;
        end_x_nxt  = in_data.x_end;
        end_y_nxt  = in_data.y_end;
        dx_nxt     = abs_dx;
        ndy_nxt    = init_ndy;
        sx_neg_nxt = !(in_data.x_start < in_data.x_end);
        sy_neg_nxt = !(in_data.y_start < in_data.y_end);
        err_nxt    = init_err;
        p_done_nxt = (in_data.x_start == in_data.x_end) &&
                     (in_data.y_start == in_data.y_end);
        active_nxt = !p_done_nxt;
        p_x_nxt    = in_data.x_start;
        p_y_nxt    = in_data.y_start;
      end else if (!active_r) begin
        p_idle_nxt = 1'b1;
        p_done_nxt = 1'b0;
      end else begin
        cur_x_nxt  = x_adv;
        cur_y_nxt  = y_adv;
        err_nxt    = err_adv;
        p_done_nxt = (x_adv == end_x_r) && (y_adv == end_y_r);
        active_nxt = !p_done_nxt;
        p_x_nxt    = x_adv;
        p_y_nxt    = y_adv;
      end
    end
  end

  always_comb begin
    w_c    = (width_r > DIM_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : width_r;
    h_c    = (height_r > DIM_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : height_r;
    on_bitmap = !p_x_r[COORD_BITS-1] && !p_y_r[COORD_BITS-1] &&
                (p_x_r[COORD_BITS-2:0] < (COORD_BITS-1)'(w_c)) &&
                (p_y_r[COORD_BITS-2:0] < (COORD_BITS-1)'(h_c));
    addr   = ADDR_BITS'(p_y_r[IDX_BITS-1:0]) * ADDR_BITS'(w_c)
           + ADDR_BITS'(p_x_r[IDX_BITS-1:0]);

    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (p_move) begin
      out_valid_nxt = 1'b1;
      if (p_idle_r) begin
        out_data_nxt          = '0;
        out_data_nxt.was_idle = 1'b1;
      end else begin
        out_data_nxt.pixel_x       = p_x_r;
        out_data_nxt.pixel_y       = p_y_r;
        out_data_nxt.write_enable  = on_bitmap;
        out_data_nxt.pixel_address = on_bitmap ? addr : '0;
        out_data_nxt.pixel_color   = color_r;
        out_data_nxt.line_done     = p_done_r;
        out_data_nxt.was_idle      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= DIM_BITS'(640);
      height_r    <= DIM_BITS'(480);
      color_r     <= '0;
      active_r    <= 1'b0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      color_r     <= color_nxt;
      active_r    <= active_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    end_x_r    <= end_x_nxt;
    end_y_r    <= end_y_nxt;
    dx_r       <= dx_nxt;
    ndy_r      <= ndy_nxt;
    sx_neg_r   <= sx_neg_nxt;
    sy_neg_r   <= sy_neg_nxt;
    err_r      <= err_nxt;
    p_x_r      <= p_x_nxt;
    p_y_r      <= p_y_nxt;
    p_done_r   <= p_done_nxt;
    p_idle_r   <= p_idle_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[hdl/blr_checker.sv]
`default_nettype none
`include "bresenham_line_rasterizer_defines.svh"

module blr_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire blr_pkg::blr_out_t out_data
);
  import blr_pkg::*;

  logic idle_word, idle_clean;

  assign idle_word  = out_valid && out_data.was_idle;
  assign idle_clean = !out_data.write_enable && !out_data.line_done &&
                      (out_data.pixel_address == '0) && (out_data.pixel_color == '0);

  `BLR_ASSERT_RST(a_reset_empty, !out_valid && !in_stall)
  `BLR_ASSERT_IMP(a_idle_word_clean, idle_word, idle_clean)
  `BLR_ASSERT_IMP(a_clip_addr_zero, out_valid && !out_data.write_enable, out_data.pixel_address == '0)
  `BLR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

[dv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import blr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  blr_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  blr_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_WIDTH;
  logic [COLOR_BITS-1:0] cfg_wdata = '0;

  bresenham_line_rasterizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the rasterizer state and registers
  bit [DIM_BITS-1:0]   fb_width = 12'd640;
  bit [DIM_BITS-1:0]   fb_height = 12'd480;
  bit [COLOR_BITS-1:0] ink = '0;
  int pen_x, pen_y, tgt_x, tgt_y;
  int span_x, neg_span_y, err_acc;
  bit x_back, y_back, drawing;

  blr_in_t  words_to_send[$];
  blr_out_t pixels_due[$];

  int errors, cycle_cnt, n_checked, n_clipped, n_ends, n_idle, n_starts, n_settings;
  int burst_left, gap_left, stall_mode, stall_hold;

  function automatic blr_out_t raster_step(blr_in_t w);
    blr_out_t px;
    int e2, cw, ch;
    bit fin;
    px = '0;
    if (w.req_type == REQ_START) begin
      pen_x = $signed(w.x_start);
      pen_y = $signed(w.y_start);
      tgt_x = $signed(w.x_end);
      tgt_y = $signed(w.y_end);
      span_x = (tgt_x > pen_x) ? tgt_x - pen_x : pen_x - tgt_x;
      neg_span_y = (tgt_y > pen_y) ? pen_y - tgt_y : tgt_y - pen_y;
      x_back = !(pen_x < tgt_x);
      y_back = !(pen_y < tgt_y);
      err_acc = span_x + neg_span_y;
    end else if (!drawing) begin
      px.was_idle = 1'b1;
      return px;
    end else begin
      e2 = 2 * err_acc;
      if (e2 >= neg_span_y) begin
        err_acc += neg_span_y;
        pen_x += x_back ? -1 : 1;
      end
      if (e2 <= span_x) begin
        err_acc += span_x;
        pen_y += y_back ? -1 : 1;
      end
    end
    fin = (pen_x == tgt_x) && (pen_y == tgt_y);
    drawing = !fin;
    cw = (fb_width > MAX_DIM) ? MAX_DIM : int'(fb_width);
    ch = (fb_height > MAX_DIM) ? MAX_DIM : int'(fb_height);
    px.pixel_x = pen_x[COORD_BITS-1:0];
    px.pixel_y = pen_y[COORD_BITS-1:0];
    if (pen_x >= 0 && pen_y >= 0 && pen_x < cw && pen_y < ch) begin
      px.write_enable = 1'b1;
      px.pixel_address = ADDR_BITS'(pen_y * cw + pen_x);
    end
    px.pixel_color = ink;
    px.line_done = fin;
    return px;
  endfunction

  task automatic cmp_field(string fname, longint want, longint got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      errors++;
    end
  endtask

  // advance words carry junk endpoints, which the block must ignore
  task automatic push_word(req_t kind, int xa, int ya, int xb, int yb);
    blr_in_t w;
    if (kind == REQ_ADVANCE) begin
      xa = $urandom;
      ya = $urandom;
      xb = $urandom;
      yb = $urandom;
    end
    w.req_type = kind;
    w.x_start = xa[COORD_BITS-1:0];
    w.y_start = ya[COORD_BITS-1:0];
    w.x_end = xb[COORD_BITS-1:0];
    w.y_end = yb[COORD_BITS-1:0];
    words_to_send.push_back(w);
  endtask

  task automatic queue_lines(int n);
    int cnt, cw, ch, x0, y0, x1, y1, len, d, steps, adv, kind;
    cnt = 0;
    cw = (fb_width > MAX_DIM) ? MAX_DIM : int'(fb_width);
    ch = (fb_height > MAX_DIM) ? MAX_DIM : int'(fb_height);
    if (cw < 16) cw = 16;
    if (ch < 16) ch = 16;
    while (cnt < n) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        x0 = int'($urandom_range(0, cw + 15)) - 8;
        y0 = int'($urandom_range(0, ch + 15)) - 8;
        len = ($urandom_range(0, 7) == 0) ? 200 : 24;
        if ($urandom_range(0, 4) == 0) begin
          x1 = x0;
          y1 = y0;
        end else begin
          d = $urandom_range(0, 2 * len);
          x1 = x0 + d - len;
          d = $urandom_range(0, 2 * len);
          y1 = y0 + d - len;
        end
        steps = (x1 > x0) ? x1 - x0 : x0 - x1;
        d = (y1 > y0) ? y1 - y0 : y0 - y1;
        if (d > steps) steps = d;
        case ($urandom_range(0, 7))
          0: adv = $urandom_range(0, steps);
          1: adv = steps + $urandom_range(1, 3);
          default: adv = steps;
        endcase
      end else if (kind <= 8) begin
        x0 = $urandom;
        y0 = $urandom;
        x1 = $urandom;
        y1 = $urandom;
        adv = $urandom_range(0, 4);
      end else begin
        adv = $urandom_range(1, 2);
      end
      if (kind <= 8) begin
        push_word(REQ_START, x0, y0, x1, y1);
        cnt++;
      end
      repeat (adv) push_word(REQ_ADVANCE, 0, 0, 0, 0);
      cnt += adv;
    end
  endtask

  task automatic set_bitmap(int w, int h, int c);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_wdata <= {12'($urandom), 12'(w)};
    fb_width = 12'(w);
    @(posedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_wdata <= {12'($urandom), 12'(h)};
    fb_height = 12'(h);
    @(posedge clk);
    cfg_index <= CFG_COLOR;
    cfg_wdata <= 24'(c);
    ink = 24'(c);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
    @(negedge clk);
  endtask

  task automatic drain();
    while (words_to_send.size() != 0 || in_valid || pixels_due.size() != 0)
      @(negedge clk);
  endtask

  // sender: bursts of words separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pixels_due.push_back(raster_step(in_data));
        if (in_data.req_type == REQ_START) n_starts++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0 || words_to_send.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_data <= words_to_send.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver: stall mode is redrawn whenever its hold counter runs out
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pixels_due.size() == 0) begin
          $display("%0t ns: unexpected pixel word, got x=%0d y=%0d idle=%0b", $time,
                   out_data.pixel_x, out_data.pixel_y, out_data.was_idle);
          errors++;
        end else begin
          cmp_field("pixel_x", pixels_due[0].pixel_x, out_data.pixel_x);
          cmp_field("pixel_y", pixels_due[0].pixel_y, out_data.pixel_y);
          cmp_field("write_enable", pixels_due[0].write_enable, out_data.write_enable);
          cmp_field("pixel_address", pixels_due[0].pixel_address, out_data.pixel_address);
          cmp_field("pixel_color", pixels_due[0].pixel_color, out_data.pixel_color);
          cmp_field("line_done", pixels_due[0].line_done, out_data.line_done);
          cmp_field("was_idle", pixels_due[0].was_idle, out_data.was_idle);
          n_checked++;
          if (pixels_due[0].was_idle) n_idle++;
          else if (!pixels_due[0].write_enable) n_clipped++;
          if (pixels_due[0].line_done) n_ends++;
          void'(pixels_due.pop_front());
        end
      end
      if (stall_hold == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_hold = $urandom_range(20, 120);
      end else begin
        stall_hold--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= cycle_cnt[2];
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d pixel words still due", $time, pixels_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int ph;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset bitmap 640x480, color 0
    push_word(REQ_ADVANCE, 0, 0, 0, 0);
    push_word(REQ_START, 5, 5, 5, 5);
    push_word(REQ_ADVANCE, 0, 0, 0, 0);
    push_word(REQ_START, 0, 0, 3, 0);
    repeat (4) push_word(REQ_ADVANCE, 0, 0, 0, 0);
    push_word(REQ_START, 10, 20, 10, 17);
    repeat (3) push_word(REQ_ADVANCE, 0, 0, 0, 0);
    push_word(REQ_START, 639, 479, 641, 480);
    repeat (2) push_word(REQ_ADVANCE, 0, 0, 0, 0);
    // full-range line, abandoned by a new start
    push_word(REQ_START, -32768, -32768, 32767, 32767);
    push_word(REQ_ADVANCE, 0, 0, 0, 0);
    push_word(REQ_START, 32767, -1, -32768, 0);
    push_word(REQ_ADVANCE, 0, 0, 0, 0);
    push_word(REQ_START, 3, 2, -1, -4);
    repeat (6) push_word(REQ_ADVANCE, 0, 0, 0, 0);
    queue_lines(100);
    drain();

    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_bitmap(1, 1, 24'hFFFFFF);
        1: set_bitmap(2048, 2048, $urandom);
        2: set_bitmap(4095, 4095, 0);
        3: set_bitmap(0, 300, $urandom);
        4: set_bitmap(300, 0, $urandom);
        default: set_bitmap(($urandom_range(0, 1) != 0) ? $urandom_range(1, 64)
                                                          : $urandom_range(1, 4095),
                            ($urandom_range(0, 1) != 0) ? $urandom_range(1, 64)
                                                          : $urandom_range(1, 4095),
                            $urandom);
      endcase
      queue_lines(100);
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Run covered %0d pixel words from %0d line starts over %0d bitmap settings:",
             n_checked, n_starts, n_settings + 1);
    $display("  %0d line ends, %0d clipped pixels, %0d idle advances",
             n_ends, n_clipped, n_idle);
    if (errors == 0 && pixels_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
